/* sv/ilfc_pkg.sv */
// Shared types and constants of the IRC line framer and classifier.
`default_nettype none

package ilfc_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam int          CMD_MAX   = 7;
    localparam int          WIN_LEN   = 12;
    localparam int          LEN_W     = 9;
    localparam logic [8:0]  LEN_MAX   = 9'd511;

    // Needles, first character in the top byte.
    localparam logic [31:0] NEEDLE_PING    = "PING";
    localparam logic [39:0] NEEDLE_ERROR   = "ERROR";
    localparam logic [95:0] NEEDLE_CLOSING = "CLOSING LINK";
    localparam logic [95:0] NEEDLE_TIMEOUT = "PING TIMEOUT";

    typedef enum logic [4:0] {
        CLS_OTHER,
        CLS_PING,
        CLS_001,
        CLS_376,
        CLS_422,
        CLS_433,
        CLS_451,
        CLS_PRIVMSG,
        CLS_JOIN,
        CLS_PART,
        CLS_QUIT,
        CLS_NICK,
        CLS_TOPIC,
        CLS_332,
        CLS_353,
        CLS_366,
        CLS_ERROR
    } cmd_class_t;

    // Command token, character k at index k.
    typedef logic [CMD_MAX-1:0][7:0] cmd_chars_t;

    // Command patterns, left-justified, zero padded; entry n is class n+1.
    localparam int CMD_COUNT = 16;
    localparam logic [8*CMD_MAX-1:0] CMD_PATTERN [CMD_COUNT] = '{
        {"PING",    24'h0},
        {"001",     32'h0},
        {"376",     32'h0},
        {"422",     32'h0},
        {"433",     32'h0},
        {"451",     32'h0},
        {"PRIVMSG"},
        {"JOIN",    24'h0},
        {"PART",    24'h0},
        {"QUIT",    24'h0},
        {"NICK",    24'h0},
        {"TOPIC",   16'h0},
        {"332",     32'h0},
        {"353",     32'h0},
        {"366",     32'h0},
        {"ERROR",   16'h0}
    };

    typedef struct packed {
        logic       fatal_flag;
        logic       notice_flag;
        logic       ping_found;
        cmd_class_t command_class;
        logic       has_prefix;
        logic [8:0] line_length;
    } result_t;

endpackage

`default_nettype wire

/* sv/ilfc_cmd_class.sv */
// Command token classifier: maps an upper-cased token to its command class.
`default_nettype none

module ilfc_cmd_class
    import ilfc_pkg::*;
(
    input  wire cmd_chars_t cmd_chars,
    input  wire logic [3:0] cmd_len,
    output cmd_class_t      cmd_class
);

    logic [8*CMD_MAX-1:0] token;

    always_comb
    begin
        // first character to the top byte
        for (int k = 0; k < CMD_MAX; k++)
        begin
            token[8*(CMD_MAX-1-k) +: 8] = cmd_chars[k];
        end
    end

    // Token bytes are never zero, so the padded compare also checks length.
    always_comb
    begin
        cmd_class = CLS_OTHER;
        if (cmd_len <= 4'(CMD_MAX))
        begin
            for (int n = CMD_COUNT - 1; n >= 0; n--)
            begin
                if (token == CMD_PATTERN[n])
                begin
                    cmd_class = cmd_class_t'(5'(n + 1));
                end
            end
        end
    end

endmodule

`default_nettype wire

/* sv/irc_line_framer_classifier.sv */
// Top level of the IRC line framer and classifier.
//
// Usage:
//   s_* carries one received byte per item in s_tdata[7:0]. Lines end at LF.
//   A CR just before the LF is dropped, content after a NUL byte is ignored,
//   empty lines give nothing, and a line that outgrows LINE_CAPACITY-1
//   stored bytes is dropped through its LF.
//   m_* carries one item per kept line, sent for its LF byte.
// Output: once its LF is accepted, the LF sits in the input register, then
//   updates into the result register that drives m_tvalid.
// Throughput: one byte per cycle while no result waits on m_tready; the
//   per-byte framing, window match and token parse are all combinational
//   between the input register and the line state / result registers.
// Stall: while a result waits on m_tready, the byte in the input register
//   is held and s_tready drops once that register is full; nothing is lost.
// Reset: rst_n clears the line state, the discard flag and both valid bits;
//   the block starts at a line start.
`default_nettype none

module irc_line_framer_classifier
    import ilfc_pkg::*;
#(
    parameter int LINE_CAPACITY = 512
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [8:0] line_length, [9] has_prefix,
                                        // [14:10] command_class, [15] ping_found,
                                        // [16] notice_flag, [17] fatal_flag, rest zero
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CNT_W-1:0] STORE_LIMIT = CNT_W'(LINE_CAPACITY - 1);

    typedef enum logic [2:0] {
        PH_START,
        PH_PREFIX,
        PH_SKIP,
        PH_CMD,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0]          byte_count;     // stored bytes, CRs and post-NUL too
        logic [CNT_W-1:0]          content_count;  // kept bytes before NUL
        logic                      pending_cr;
        logic                      zero_seen;
        phase_t                    phase;
        logic                      prefix_seen;
        cmd_chars_t                cmd_chars;
        logic [3:0]                cmd_len;        // saturates at CMD_MAX+1
        logic [WIN_LEN-1:0][7:0]   recent;         // newest at index 0
        logic [3:0]                match_flags;    // PING, ERROR, CLOSING, TIMEOUT
    } line_state_t;

    // One content byte into the line state.
    function automatic line_state_t feed(line_state_t s, logic [7:0] c);
        line_state_t r;
        logic [7:0]  uc;
        logic        add_cmd;
        r       = s;
        uc      = (c >= CHAR_LC_A && c <= CHAR_LC_Z) ? (c - CASE_DIFF) : c;
        add_cmd = 1'b0;
        if (!s.zero_seen)
        begin
            if (c == CHAR_NUL)
            begin
                r.zero_seen = 1'b1;
            end
            else
            begin
                r.content_count = s.content_count + CNT_W'(1);
                r.recent = {s.recent[WIN_LEN-2:0], uc};
                if (r.recent[3:0] == NEEDLE_PING)
                    r.match_flags[0] = 1'b1;
                if (r.recent[4:0] == NEEDLE_ERROR)
                    r.match_flags[1] = 1'b1;
                if (r.recent == NEEDLE_CLOSING)
                    r.match_flags[2] = 1'b1;
                if (r.recent == NEEDLE_TIMEOUT)
                    r.match_flags[3] = 1'b1;
                case (s.phase)
                    PH_START:
                    begin
                        if (c == CHAR_COLON)
                        begin
                            r.prefix_seen = 1'b1;
                            r.phase       = PH_PREFIX;
                        end
                        else if (c == CHAR_SPACE)
                        begin
                            r.phase = PH_DONE;
                        end
                        else
                        begin
                            add_cmd = 1'b1;
                            r.phase = PH_CMD;
                        end
                    end
                    PH_PREFIX:
                    begin
                        if (c == CHAR_SPACE)
                            r.phase = PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        if (c != CHAR_SPACE)
                        begin
                            add_cmd = 1'b1;
                            r.phase = PH_CMD;
                        end
                    end
                    PH_CMD:
                    begin
                        if (c == CHAR_SPACE)
                            r.phase = PH_DONE;
                        else
                            add_cmd = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (add_cmd)
                begin
                    if (s.cmd_len < 4'(CMD_MAX))
                        r.cmd_chars[s.cmd_len[2:0]] = uc;
                    if (s.cmd_len <= 4'(CMD_MAX))
                        r.cmd_len = s.cmd_len + 4'd1;
                end
            end
        end
        return r;
    endfunction

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // line state
    line_state_t st_reg, st_next;
    logic        disc_reg, disc_next;

    // result register
    logic        out_valid_reg;
    result_t     out_reg;

    logic        proc_ready;
    logic        proc_fire;
    logic        emit;
    result_t     result;
    cmd_class_t  cmd_class;
    logic [EXT_W-1:0] count_ext;

    assign proc_ready = !out_valid_reg || m_tready;
    assign proc_fire  = in_valid_reg && proc_ready;
    assign s_tready   = !in_valid_reg || proc_ready;

    ilfc_cmd_class u_cmd_class (
        .cmd_chars (st_reg.cmd_chars),
        .cmd_len   (st_reg.cmd_len),
        .cmd_class (cmd_class)
    );

    // Result fields from the line state before its LF clears it.
    always_comb
    begin
        count_ext            = EXT_W'(st_reg.content_count);
        result.line_length   = (count_ext > EXT_W'(LEN_MAX)) ? LEN_MAX : count_ext[LEN_W-1:0];
        result.has_prefix    = st_reg.prefix_seen;
        result.command_class = cmd_class;
        result.ping_found    = st_reg.match_flags[0];
        result.notice_flag   = |st_reg.match_flags[3:1];
        result.fatal_flag    = (cmd_class == CLS_ERROR) || (|st_reg.match_flags[3:2]);
    end

    // Per-byte framing.
    always_comb
    begin
        line_state_t s;
        s         = st_reg;
        st_next   = st_reg;
        disc_next = disc_reg;
        emit      = 1'b0;
        if (in_byte_reg == CHAR_LF)
        begin
            emit      = !disc_reg && (st_reg.content_count != '0);
            st_next   = '0;
            disc_next = 1'b0;
        end
        else if (!disc_reg)
        begin
            if (st_reg.byte_count < STORE_LIMIT)
            begin
                s.byte_count = st_reg.byte_count + CNT_W'(1);
                // a held CR turns out to be content
                if (st_reg.pending_cr)
                begin
                    s = feed(s, CHAR_CR);
                    s.pending_cr = 1'b0;
                end
                if (in_byte_reg == CHAR_CR)
                    s.pending_cr = 1'b1;
                else
                    s = feed(s, in_byte_reg);
                st_next = s;
            end
            else
            begin
                // overflow: drop the line through its LF
                st_next   = '0;
                disc_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            disc_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (proc_fire)
            begin
                st_reg   <= st_next;
                disc_reg <= disc_next;
            end
            if (proc_fire && emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (proc_fire && emit)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 24'(out_reg);

`ifndef SYNTHESIS
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.line_length != '0))
        else $error("result with empty line");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.content_count <= st_reg.byte_count)
        else $error("content count above stored count");

    a_discard_clear: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (st_reg.byte_count == '0 && !st_reg.pending_cr))
        else $error("line state kept while discarding");

    a_fatal_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.fatal_flag) |->
            (out_reg.notice_flag || out_reg.command_class == CLS_ERROR))
        else $error("fatal flag without cause");

    a_cr_stored: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pending_cr |-> (st_reg.byte_count != '0))
        else $error("held CR not counted");
`endif

endmodule

`default_nettype wire
